@@ sv/flow_delivery_detector_top_defines.svh @@
// ----------------------------------------------------------------------------
// Flow delivery detector assertion macros
// Shared concurrent assertion shorthands for the delivery detector.
// ----------------------------------------------------------------------------
`ifndef FLOW_DELIVERY_DETECTOR_TOP_DEFINES_SVH
`define FLOW_DELIVERY_DETECTOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and quiet during reset.
`define FDD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fdd: same-cycle check failed");

// Next-cycle implication, sampled on clk_i and quiet during reset.
`define FDD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fdd: next-cycle check failed");

`endif

@@ sv/fdd_pkg.sv @@
// ----------------------------------------------------------------------------
// Flow delivery detector package
// Widths, reset values, register indexes and divider constants.
// ----------------------------------------------------------------------------
package fdd_pkg;

  // Field widths.
  localparam int FLOW_W     = 16;
  localparam int TIME_W     = 32;
  localparam int ACC_W      = 48;
  localparam int ML_W       = 32;
  localparam int DUR_W      = 23;
  localparam int DELAY_W    = 12;
  localparam int DELAY_MS_W = 22;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;

  // Default clamp on the time between samples, in ms.
  localparam int DT_CLAMP_MS = 1000;

  // Configuration reset values.
  localparam logic signed [FLOW_W-1:0]   START_THR_RST   = 16'sd100;
  localparam logic signed [FLOW_W-1:0]   END_THR_RST     = 16'sd50;
  localparam logic [DELAY_MS_W-1:0]      END_DELAY_MS_RST = 22'd10000;
  localparam logic [DELAY_MS_W-1:0]      MS_PER_S        = 22'd1000;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_THR = 2'd0,
    CFG_END_THR   = 2'd1,
    CFG_END_DELAY = 2'd2
  } cfg_idx_e;

  // Millilitres are floor(acc / 12000). At or above 12000 * 2^32 the result
  // saturates. Below that, acc >> 5 fits 41 bits and is divided by 375 as a
  // 25-bit high part and a 16-bit low part, each by a reciprocal multiply.
  localparam logic [ACC_W-1:0] ML_SAT_LIMIT = 48'd51539607552000;
  localparam int               DIV_IN_W     = 25;
  localparam int               DIV_M_W      = 26;
  localparam int               DIV_P_W      = DIV_IN_W + DIV_M_W;
  localparam logic [DIV_M_W-1:0] DIV375_M   = 26'd45812985;
  localparam int               DIV375_SH    = 34;
  localparam logic [DIV_IN_W-1:0] DIV_K     = 25'd375;
  localparam int               REM_W        = 9;
  localparam int               LO_W         = 16;
  localparam int               Q1_W         = 17;

  // Seconds are floor(ms / 1000) by reciprocal multiply, exact for 32 bits.
  localparam int               DUR_M_W      = 29;
  localparam logic [DUR_M_W-1:0] DUR_M      = 29'd274877907;
  localparam int               DUR_SH       = 38;
  localparam int               DUR_P_W      = TIME_W + DUR_M_W;

endpackage

@@ sv/flow_delivery_detector_top.sv @@
// A result item is registered in stages A to G in turn after the edge that
// accepts its input item, and may wait on out_ready_i behind earlier results.
// Throughput: one item per cycle unless out_ready_i holds the output back;
// a 7-stage pipeline whose stages fill independently, with the delivery
// state updated in the third stage. Reset clears control state (not stage
// data) and restores the configuration defaults at once; no clearing pass.
// ----------------------------------------------------------------------------
// Flow delivery detector
// Finds deliveries in timestamped flow samples, integrates their volume and
// reports live and completed delivery figures for every sample.
// ----------------------------------------------------------------------------
`include "flow_delivery_detector_top_defines.svh"

module flow_delivery_detector_top #(
  parameter int DtClampMs = fdd_pkg::DT_CLAMP_MS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [fdd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fdd_pkg::CFG_W-1:0]          cfg_data_i,
  // Sample input channel.
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [fdd_pkg::TIME_W-1:0]         now_ms_i,
  input  logic signed [fdd_pkg::FLOW_W-1:0]  flow_rate_i,
  // Result output channel.
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         mode_o,
  output logic [fdd_pkg::ML_W-1:0]           live_volume_ml_o,
  output logic [fdd_pkg::DUR_W-1:0]          live_duration_s_o,
  output logic                               delivery_done_o,
  output logic [fdd_pkg::TIME_W-1:0]         delivery_id_o,
  output logic [fdd_pkg::DUR_W-1:0]          record_duration_s_o,
  output logic [fdd_pkg::ML_W-1:0]           record_volume_ml_o
);

  localparam int DtW    = $clog2(DtClampMs + 1);
  localparam int IncW   = fdd_pkg::FLOW_W + DtW;
  localparam int NumStg = 7;
  localparam int StgC   = 2;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DELIV = 2'd1,
    PH_DONE  = 2'd2
  } phase_e;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic signed [fdd_pkg::FLOW_W-1:0]   start_thr_q;
  logic signed [fdd_pkg::FLOW_W-1:0]   end_thr_q;
  logic [fdd_pkg::DELAY_MS_W-1:0]      end_delay_ms_q;

  // The end delay is kept in ms so the countdown needs no multiply.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_thr_q    <= fdd_pkg::START_THR_RST;
      end_thr_q      <= fdd_pkg::END_THR_RST;
      end_delay_ms_q <= fdd_pkg::END_DELAY_MS_RST;
    end else if (cfg_we_i) begin
      unique case (fdd_pkg::cfg_idx_e'(cfg_idx_i))
        fdd_pkg::CFG_START_THR: start_thr_q <= cfg_data_i;
        fdd_pkg::CFG_END_THR:   end_thr_q   <= cfg_data_i;
        fdd_pkg::CFG_END_DELAY: begin
          end_delay_ms_q <= fdd_pkg::DELAY_MS_W'(cfg_data_i[fdd_pkg::DELAY_W-1:0])
                            * fdd_pkg::MS_PER_S;
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its item leaves.
  // --------------------------------------------------------------------------
  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] ld_ok;
  logic [NumStg-1:0] mv;

  always_comb begin
    ld_ok[NumStg-1] = !vld_q[NumStg-1] || out_ready_i;
    for (int k = NumStg - 2; k >= 0; k--) begin
      ld_ok[k] = !vld_q[k] || ld_ok[k+1];
    end
    mv[0] = ld_ok[0] && in_valid_i;
    for (int k = 1; k < NumStg; k++) begin
      mv[k] = ld_ok[k] && vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld_ok[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStg; k++) begin
        if (ld_ok[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = ld_ok[0];
  assign out_valid_o = vld_q[NumStg-1];

  // --------------------------------------------------------------------------
  // Stage A: time step and flow sum against the previous item, threshold tests.
  // --------------------------------------------------------------------------
  logic [fdd_pkg::TIME_W-1:0]          last_sample_q;
  logic signed [fdd_pkg::FLOW_W-1:0]   prev_flow_q;
  logic [fdd_pkg::TIME_W-1:0]          a_now_q;
  logic [DtW-1:0]                      a_dt_q;
  logic signed [fdd_pkg::FLOW_W:0]     a_sum_q;
  logic                                a_start_hit_q;
  logic                                a_end_low_q;
  logic [fdd_pkg::TIME_W-1:0]          dt_raw;
  logic [DtW-1:0]                      dt_clamped;

  assign dt_raw     = now_ms_i - last_sample_q;
  assign dt_clamped = (dt_raw > fdd_pkg::TIME_W'(DtClampMs)) ? DtW'(DtClampMs)
                                                             : dt_raw[DtW-1:0];

  // The previous time and flow advance on every item, whatever the phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_sample_q <= '0;
      prev_flow_q   <= '0;
    end else if (mv[0]) begin
      last_sample_q <= now_ms_i;
      prev_flow_q   <= flow_rate_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv[0]) begin
      a_now_q       <= now_ms_i;
      a_dt_q        <= dt_clamped;
      a_sum_q       <= (fdd_pkg::FLOW_W+1)'(flow_rate_i) + (fdd_pkg::FLOW_W+1)'(prev_flow_q);
      a_start_hit_q <= flow_rate_i > start_thr_q;
      a_end_low_q   <= flow_rate_i < end_thr_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: trapezoid increment, kept only when the flow sum is positive.
  // --------------------------------------------------------------------------
  logic [fdd_pkg::TIME_W-1:0] b_now_q;
  logic [IncW-1:0]            b_inc_q;
  logic                       b_start_hit_q;
  logic                       b_end_low_q;
  logic                       sum_pos;

  assign sum_pos = !a_sum_q[fdd_pkg::FLOW_W] && (a_sum_q != '0);

  always_ff @(posedge clk_i) begin
    if (mv[1]) begin
      b_now_q       <= a_now_q;
      b_inc_q       <= sum_pos ? IncW'(a_sum_q[fdd_pkg::FLOW_W-1:0]) * IncW'(a_dt_q)
                               : '0;
      b_start_hit_q <= a_start_hit_q;
      b_end_low_q   <= a_end_low_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: delivery state machine and saturating volume accumulator.
  // --------------------------------------------------------------------------
  phase_e                       phase_q, phase_d;
  logic [fdd_pkg::TIME_W-1:0]   start_q, start_d;
  logic [fdd_pkg::TIME_W-1:0]   low_since_q, low_since_d;
  logic                         low_act_q, low_act_d;
  logic [fdd_pkg::ACC_W-1:0]    acc_q, acc_d;
  logic [fdd_pkg::TIME_W-1:0]   count_q, count_d;
  logic                         done_d;
  logic                         c_done_q;
  logic [fdd_pkg::TIME_W-1:0]   c_diff_q;
  logic [fdd_pkg::ACC_W:0]      acc_sum;
  logic [fdd_pkg::TIME_W-1:0]   low_elapsed;

  assign acc_sum     = {1'b0, acc_q} + (fdd_pkg::ACC_W+1)'(b_inc_q);
  assign low_elapsed = b_now_q - low_since_q;

  always_comb begin
    phase_d     = phase_q;
    start_d     = start_q;
    low_since_d = low_since_q;
    low_act_d   = low_act_q;
    acc_d       = acc_q;
    count_d     = count_q;
    done_d      = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        if (b_start_hit_q) begin
          phase_d   = PH_DELIV;
          acc_d     = '0;
          start_d   = b_now_q;
          low_act_d = 1'b0;
        end
      end
      PH_DELIV: begin
        acc_d = acc_sum[fdd_pkg::ACC_W] ? '1 : acc_sum[fdd_pkg::ACC_W-1:0];
        if (b_end_low_q) begin
          // The first low sample arms the countdown; later ones test it.
          if (!low_act_q) begin
            low_act_d   = 1'b1;
            low_since_d = b_now_q;
          end else if (low_elapsed >= fdd_pkg::TIME_W'(end_delay_ms_q)) begin
            count_d   = count_q + 1'b1;
            phase_d   = PH_DONE;
            low_act_d = 1'b0;
            done_d    = 1'b1;
          end
        end else begin
          low_act_d = 1'b0;
        end
      end
      PH_DONE: phase_d = PH_IDLE;
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      start_q     <= '0;
      low_since_q <= '0;
      low_act_q   <= 1'b0;
      acc_q       <= '0;
      count_q     <= '0;
    end else if (mv[StgC]) begin
      phase_q     <= phase_d;
      start_q     <= start_d;
      low_since_q <= low_since_d;
      low_act_q   <= low_act_d;
      acc_q       <= acc_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv[StgC]) begin
      c_done_q <= done_d;
      c_diff_q <= b_now_q - start_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: saturation test, high-half reciprocal and seconds reciprocal.
  // --------------------------------------------------------------------------
  phase_e                            d_phase_q;
  logic                              d_done_q;
  logic [fdd_pkg::TIME_W-1:0]        d_count_q;
  logic                              d_sat_q;
  logic [fdd_pkg::DIV_IN_W-1:0]      d_hi_q;
  logic [fdd_pkg::LO_W-1:0]          d_lo_q;
  logic [fdd_pkg::DIV_P_W-1:0]       d_p1_q;
  logic [fdd_pkg::DUR_P_W-1:0]       d_pd_q;

  always_ff @(posedge clk_i) begin
    if (mv[3]) begin
      d_phase_q <= phase_q;
      d_done_q  <= c_done_q;
      d_count_q <= count_q;
      d_sat_q   <= acc_q >= fdd_pkg::ML_SAT_LIMIT;
      d_hi_q    <= acc_q[45:21];
      d_lo_q    <= acc_q[20:5];
      d_p1_q    <= fdd_pkg::DIV_P_W'(acc_q[45:21]) * fdd_pkg::DIV_P_W'(fdd_pkg::DIV375_M);
      d_pd_q    <= fdd_pkg::DUR_P_W'(c_diff_q) * fdd_pkg::DUR_P_W'(fdd_pkg::DUR_M);
    end
  end

  // --------------------------------------------------------------------------
  // Stage E: high quotient, its remainder and the elapsed seconds.
  // --------------------------------------------------------------------------
  phase_e                         e_phase_q;
  logic                           e_done_q;
  logic [fdd_pkg::TIME_W-1:0]     e_count_q;
  logic                           e_sat_q;
  logic [fdd_pkg::LO_W-1:0]       e_lo_q;
  logic [fdd_pkg::Q1_W-1:0]       e_q1_q;
  logic [fdd_pkg::REM_W-1:0]      e_r1_q;
  logic [fdd_pkg::DUR_W-1:0]      e_dur_q;
  logic [fdd_pkg::Q1_W-1:0]       q1;
  logic [fdd_pkg::DIV_IN_W-1:0]   r1_full;

  assign q1      = d_p1_q[fdd_pkg::DIV375_SH +: fdd_pkg::Q1_W];
  assign r1_full = d_hi_q - fdd_pkg::DIV_IN_W'(q1) * fdd_pkg::DIV_K;

  always_ff @(posedge clk_i) begin
    if (mv[4]) begin
      e_phase_q <= d_phase_q;
      e_done_q  <= d_done_q;
      e_count_q <= d_count_q;
      e_sat_q   <= d_sat_q;
      e_lo_q    <= d_lo_q;
      e_q1_q    <= q1;
      e_r1_q    <= r1_full[fdd_pkg::REM_W-1:0];
      e_dur_q   <= d_pd_q[fdd_pkg::DUR_SH +: fdd_pkg::DUR_W];
    end
  end

  // --------------------------------------------------------------------------
  // Stage F: reciprocal of the remainder joined with the low half.
  // --------------------------------------------------------------------------
  phase_e                         f_phase_q;
  logic                           f_done_q;
  logic [fdd_pkg::TIME_W-1:0]     f_count_q;
  logic                           f_sat_q;
  logic [fdd_pkg::Q1_W-1:0]       f_q1_q;
  logic [fdd_pkg::DIV_P_W-1:0]    f_p2_q;
  logic [fdd_pkg::DUR_W-1:0]      f_dur_q;

  always_ff @(posedge clk_i) begin
    if (mv[5]) begin
      f_phase_q <= e_phase_q;
      f_done_q  <= e_done_q;
      f_count_q <= e_count_q;
      f_sat_q   <= e_sat_q;
      f_q1_q    <= e_q1_q;
      f_p2_q    <= fdd_pkg::DIV_P_W'({e_r1_q, e_lo_q}) * fdd_pkg::DIV_P_W'(fdd_pkg::DIV375_M);
      f_dur_q   <= e_dur_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage G: result register; the record fields hold the last completion.
  // --------------------------------------------------------------------------
  phase_e                       out_mode_q;
  logic [fdd_pkg::ML_W-1:0]     out_live_vol_q;
  logic [fdd_pkg::DUR_W-1:0]    out_live_dur_q;
  logic                         out_done_q;
  logic [fdd_pkg::TIME_W-1:0]   out_id_q;
  logic [fdd_pkg::DUR_W-1:0]    out_rec_dur_q;
  logic [fdd_pkg::ML_W-1:0]     out_rec_vol_q;
  logic [fdd_pkg::ML_W-1:0]     ml;

  // Below the saturation limit the high quotient fits 16 bits.
  assign ml = f_sat_q ? '1
                      : {f_q1_q[fdd_pkg::LO_W-1:0],
                         f_p2_q[fdd_pkg::DIV375_SH +: fdd_pkg::LO_W]};

  always_ff @(posedge clk_i) begin
    if (mv[6]) begin
      out_mode_q     <= f_phase_q;
      out_live_vol_q <= (f_phase_q == PH_DELIV) ? ml : '0;
      out_live_dur_q <= (f_phase_q == PH_DELIV) ? f_dur_q : '0;
      out_done_q     <= f_done_q;
      out_id_q       <= f_count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_rec_dur_q <= '0;
      out_rec_vol_q <= '0;
    end else if (mv[6] && f_done_q) begin
      out_rec_dur_q <= f_dur_q;
      out_rec_vol_q <= ml;
    end
  end

  assign mode_o              = out_mode_q;
  assign live_volume_ml_o    = out_live_vol_q;
  assign live_duration_s_o   = out_live_dur_q;
  assign delivery_done_o     = out_done_q;
  assign delivery_id_o       = out_id_q;
  assign record_duration_s_o = out_rec_dur_q;
  assign record_volume_ml_o  = out_rec_vol_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `FDD_ASSERT_IMP(a_done_mode, out_valid_o && delivery_done_o, out_mode_q == PH_DONE)
  `FDD_ASSERT_IMP(a_live_zero, out_valid_o && (out_mode_q != PH_DELIV),
                  (live_volume_ml_o == '0) && (live_duration_s_o == '0))
  `FDD_ASSERT_IMP(a_idle_unarmed, phase_q != PH_DELIV, !low_act_q)
  `FDD_ASSERT_NXT(a_done_count, mv[StgC] && done_d, count_q == $past(count_q) + 1'b1)

endmodule
